>>> rtl/core/header_field_compressor_defines.svh
// Assertion macros for the checker file of the header field compressor.
`ifndef HEADER_FIELD_COMPRESSOR_DEFINES_SVH
`define HEADER_FIELD_COMPRESSOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HFC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("header field compressor check failed");

// The consequent must hold in the cycle after the antecedent.
`define HFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("header field compressor check failed");

`endif

>>> rtl/core/hfc_pkg.sv
package hfc_pkg;

  // Compress searches only the first seven positions, since the offset has three bits.
  localparam int unsigned MaxOffset = 7;
  // Wide enough for any list position of the supported depths.
  localparam int unsigned PosW = 4;

  typedef enum logic [1:0] {
    LIST_HOLD,
    LIST_PUSH,
    LIST_MOVE
  } list_op_e;

  typedef struct packed {
    list_op_e         op;
    logic [PosW-1:0]  pos;
    logic [31:0]      value;
  } list_cmd_t;

  // Members run from the highest bits down, so the last field lands in bit 0.
  typedef struct packed {
    logic [31:0]        previous_target;
    logic [31:0]        previous_time;
    logic               target_flag_in;
    logic [31:0]        target_word;
    logic               time_flag_in;
    logic signed [15:0] time_offset_in;
    logic [31:0]        time_word;
    logic [2:0]         version_offset_in;
    logic signed [31:0] version_word;
    logic               has_previous;
  } in_item_t;

  typedef struct packed {
    logic               prev_hash_flag;
    logic               target_flag_out;
    logic [31:0]        target_out;
    logic               time_flag_out;
    logic signed [15:0] time_offset_out;
    logic [31:0]        time_out;
    logic [2:0]         version_offset_out;
    logic signed [31:0] version_out;
  } out_item_t;

  localparam int unsigned InDataW  = (($bits(in_item_t) + 7) / 8) * 8;
  localparam int unsigned OutDataW = (($bits(out_item_t) + 7) / 8) * 8;

endpackage

>>> rtl/core/header_field_compressor.sv
// Channel       | Direction | Handshake                 | Contents
// s_axis        | in        | s_axis_tvalid/tready      | one header, packed in_item fields
// m_axis        | out       | m_axis_tvalid/tready      | one result, packed out_item fields
// APB           | in        | psel/penable/pwrite       | direction register at address 0
//
// An item passes through accept, time add and list update. Compress with a previous
// header also searches the list before the update, one entry a cycle through a single
// comparator, up to min(list fill, 7) compares.
// Reset clears the list fill count and the direction; list words are written before use.
// A result waits in the output register; the next item is taken meanwhile, but its
// list update holds until the output register is free.
module header_field_compressor #(
  parameter int unsigned LIST_DEPTH = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // has_previous, version_word, version_offset_in, time_word, time_offset_in,
  // time_flag_in, target_word, target_flag_in, previous_time, previous_target, zero pad
  input  logic [hfc_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // version_out, version_offset_out, time_out, time_offset_out, time_flag_out,
  // target_out, target_flag_out, prev_hash_flag, zero pad
  output logic [hfc_pkg::OutDataW-1:0] m_axis_tdata_o,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [2:0]                   paddr_i,
  input  logic [31:0]                  pwdata_i,
  output logic [31:0]                  prdata_o,
  output logic                         pready_o
);

  localparam int unsigned IdxW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StCalc   = 2'd1;
  localparam logic [1:0] StSearch = 2'd2;
  localparam logic [1:0] StUpdate = 2'd3;

  localparam logic [2:0] AddrDirection = 3'd0;

  logic [1:0]           state_q, state_d;
  hfc_pkg::in_item_t    in_q;
  hfc_pkg::out_item_t   out_q, out_d;
  logic                 out_valid_q;
  logic                 dir_q;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic                 found_q, found_d;
  logic [32:0]          sum_q, sum_d;
  logic [32:0]          add_a, add_b;
  logic                 add_cin;
  hfc_pkg::list_cmd_t   cmd;
  logic [31:0]          rd_data;
  logic [CntW-1:0]      count;
  logic                 in_xfer, load, hit, last_cmp, fits, voff_ok;

  hfc_list #(.Depth(LIST_DEPTH)) u_list (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rd_idx_i  (idx_q),
    .rd_data_o (rd_data),
    .count_o   (count)
  );

  // Configuration port.
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i == AddrDirection) ? {31'd0, dir_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
    end else if (psel_i && penable_i && pwrite_i && paddr_i == AddrDirection) begin
      dir_q <= pwdata_i[0];
    end
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign load            = (state_q == StUpdate) && (!out_valid_q || m_axis_tready_i);

  // Shared adder: the time difference in compress, the time restore in uncompress.
  always_comb begin
    if (!dir_q) begin
      add_a   = {1'b0, in_q.time_word};
      add_b   = {1'b1, ~in_q.previous_time};
      add_cin = 1'b1;
    end else begin
      add_a   = {1'b0, in_q.previous_time};
      add_b   = {{17{in_q.time_offset_in[15]}}, in_q.time_offset_in};
      add_cin = 1'b0;
    end
  end

  assign hit      = (rd_data == in_q.version_word);
  assign last_cmp = (32'(idx_q) + 32'd1 >= 32'(count)) ||
                    (32'(idx_q) + 32'd1 >= hfc_pkg::MaxOffset);
  assign fits     = (sum_q[32:15] == '0) || (sum_q[32:15] == '1);
  assign voff_ok  = 32'(in_q.version_offset_in) <= 32'(count);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    found_d = found_q;
    sum_d   = sum_q;
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          state_d = StCalc;
        end
      end
      StCalc: begin
        sum_d   = add_a + add_b + 33'(add_cin);
        found_d = 1'b0;
        if (dir_q) begin
          idx_d   = IdxW'(in_q.version_offset_in - 3'd1);
          state_d = StUpdate;
        end else begin
          idx_d   = '0;
          state_d = (in_q.has_previous && count != '0) ? StSearch : StUpdate;
        end
      end
      StSearch: begin
        if (hit) begin
          found_d = 1'b1;
          state_d = StUpdate;
        end else if (last_cmp) begin
          state_d = StUpdate;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      StUpdate: begin
        if (load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Result and list update, applied at the edge that loads the output register.
  always_comb begin
    out_d                    = '0;
    out_d.version_out        = in_q.version_word;
    out_d.time_out           = in_q.time_word;
    out_d.target_out         = in_q.target_word;
    out_d.prev_hash_flag     = in_q.has_previous;
    cmd.op                   = hfc_pkg::LIST_PUSH;
    cmd.pos                  = hfc_pkg::PosW'(idx_q);
    cmd.value                = in_q.version_word;
    if (in_q.has_previous) begin
      if (!dir_q) begin
        if (found_q) begin
          out_d.version_offset_out = 3'(idx_q) + 3'd1;
          cmd.op                   = hfc_pkg::LIST_MOVE;
        end
        if (fits) begin
          out_d.time_offset_out = sum_q[15:0];
          out_d.time_flag_out   = 1'b1;
        end
        out_d.target_flag_out = (in_q.target_word == in_q.previous_target);
      end else begin
        if (in_q.version_offset_in != 3'd0) begin
          if (voff_ok) begin
            out_d.version_out = rd_data;
            cmd.op            = hfc_pkg::LIST_MOVE;
          end else begin
            cmd.op = hfc_pkg::LIST_HOLD;
          end
        end
        if (in_q.time_flag_in) begin
          out_d.time_out = sum_q[31:0];
        end
        if (in_q.target_flag_in) begin
          out_d.target_out = in_q.previous_target;
        end
        out_d.time_flag_out   = in_q.time_flag_in;
        out_d.target_flag_out = in_q.target_flag_in;
      end
    end
    if (!load) begin
      cmd.op = hfc_pkg::LIST_HOLD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
      idx_q   <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (in_xfer) begin
      in_q <= s_axis_tdata_i[$bits(hfc_pkg::in_item_t)-1:0];
    end
    if (load) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = hfc_pkg::OutDataW'(out_q);

endmodule

>>> rtl/core/hfc_list.sv
module hfc_list #(
  parameter int unsigned Depth = 7,
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hfc_pkg::list_cmd_t cmd_i,
  input  logic [IdxW-1:0]   rd_idx_i,
  output logic [31:0]       rd_data_o,
  output logic [CntW-1:0]   count_o
);

  logic [31:0]     entry_q [Depth];
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] move_idx;
  logic [31:0]     move_word;

  assign move_idx  = cmd_i.pos[IdxW-1:0];
  assign move_word = (32'(move_idx) < Depth) ? entry_q[move_idx] : '0;
  assign rd_data_o = (32'(rd_idx_i) < Depth) ? entry_q[rd_idx_i] : '0;
  assign count_o   = count_q;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    if (g == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        case (cmd_i.op)
          hfc_pkg::LIST_PUSH: entry_q[0] <= cmd_i.value;
          hfc_pkg::LIST_MOVE: entry_q[0] <= move_word;
          default: ;
        endcase
      end
    end else begin : g_tail
      always_ff @(posedge clk_i) begin
        case (cmd_i.op)
          hfc_pkg::LIST_PUSH: entry_q[g] <= entry_q[g-1];
          hfc_pkg::LIST_MOVE: begin
            if (32'(g) <= 32'(cmd_i.pos)) begin
              entry_q[g] <= entry_q[g-1];
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.op == hfc_pkg::LIST_PUSH && 32'(count_q) < Depth) begin
      count_q <= count_q + CntW'(1);
    end
  end

endmodule

>>> rtl/core/hfc_checker.sv
`include "header_field_compressor_defines.svh"

module hfc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [hfc_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic                         pready_o
);

  logic out_stalled;
  logic no_prev_out;
  logic flags_clear;

  assign out_stalled = m_axis_tvalid_o && !m_axis_tready_i;
  assign no_prev_out = m_axis_tvalid_o && !m_axis_tdata_o[117];
  assign flags_clear = (m_axis_tdata_o[116] == 1'b0) && (m_axis_tdata_o[83:67] == '0) &&
                       (m_axis_tdata_o[34:32] == '0);

  // A stalled result keeps its data.
  `HFC_ASSERT_NEXT(a_out_hold, out_stalled, m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // An accepted header keeps the input closed while it is processed.
  `HFC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

  // Without a previous header, no field is reported as compressed.
  `HFC_ASSERT_SAME(a_no_prev_plain, no_prev_out, flags_clear)

  // The bus never waits on the configuration side.
  `HFC_ASSERT_SAME(a_pready_high, rst_ni, pready_o)

endmodule

bind header_field_compressor hfc_checker u_hfc_checker (.*);
